FILE: hw/rtl/spritz_sponge_engine_defines.svh
// ----------------------------------------------------------------------------
// Spritz sponge engine - assertion macros
// Shared assertion wrappers, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SPRITZ_SPONGE_ENGINE_DEFINES_SVH
`define SPRITZ_SPONGE_ENGINE_DEFINES_SVH

// Property holds at every edge out of reset.
`define SSE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define SSE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/sse_pkg.sv
// ----------------------------------------------------------------------------
// Spritz sponge engine - package
// Sizes, command codes and the permutation memory request type.
// ----------------------------------------------------------------------------
package sse_pkg;

  localparam int PermSize   = 256;
  localparam int IdxW       = $clog2(PermSize);
  localparam int HalfSize   = PermSize / 2;
  localparam int CrushW     = $clog2(HalfSize);
  localparam int WhipRounds = 2 * PermSize;
  localparam int RoundW     = $clog2(WhipRounds);
  localparam int ShufPhases = 5;
  localparam int PhaseW     = $clog2(ShufPhases);
  localparam int NibW       = 4;
  localparam int CmdW       = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_ABSORB = 2'd0,
    CMD_STOP   = 2'd1,
    CMD_DRIP   = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [IdxW-1:0] raddr;
    logic            we;
    logic [IdxW-1:0] waddr;
    logic [IdxW-1:0] wdata;
  } mem_req_t;

endpackage

FILE: hw/rtl/sse_if.sv
// ----------------------------------------------------------------------------
// Spritz sponge engine - stream interfaces
// Command channel and keystream channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sse_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface sse_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_byte;

  modport source (output valid, output key_byte, input ready);
  modport sink   (input valid, input key_byte, output ready);
endinterface

FILE: hw/rtl/sse_perm_mem.sv
// ----------------------------------------------------------------------------
// Spritz sponge engine - permutation memory
// One write and one read port, registered read data, write-first
// forwarding. Per-entry valid bits make unwritten entries read as identity.
// ----------------------------------------------------------------------------
`include "spritz_sponge_engine_defines.svh"

module sse_perm_mem (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sse_pkg::mem_req_t       req_i,
  output logic [sse_pkg::IdxW-1:0] rdata_o
);
  import sse_pkg::*;

  logic [IdxW-1:0]     mem_q [PermSize];
  logic [PermSize-1:0] vld_q;
  logic [IdxW-1:0]     rd_q;
  logic [IdxW-1:0]     raddr_q;
  logic [IdxW-1:0]     fwd_data_q;
  logic                hit_q;
  logic                fwd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rd_q       <= mem_q[req_i.raddr];
    raddr_q    <= req_i.raddr;
    fwd_data_q <= req_i.wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      hit_q <= 1'b0;
      fwd_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      hit_q <= vld_q[req_i.raddr];
      fwd_q <= req_i.we && (req_i.waddr == req_i.raddr);
    end
  end

  // never-written entries read back as their own address (identity)
  assign rdata_o = fwd_q ? fwd_data_q : (hit_q ? rd_q : raddr_q);

  `SSE_ASSERT(a_req_known, !$isunknown(req_i), "memory request unknown")
  `SSE_ASSERT_NEXT(a_vld_set, req_i.we, vld_q[$past(req_i.waddr)], "write did not mark entry")
  `SSE_ASSERT_NEXT(a_fwd_data, req_i.we && (req_i.waddr == req_i.raddr), rdata_o == $past(req_i.wdata), "forwarding lost write data")

endmodule

FILE: hw/rtl/spritz_sponge_engine.sv
// ----------------------------------------------------------------------------
// Spritz sponge engine (N = 256)
// Commands absorb a byte, absorb a stop marker or drip one keystream byte.
// The 256-byte permutation sits in a single-port-read, single-port-write
// memory and each cipher state makes at most one memory access, so the
// memory ports set the rate: absorb stop only steps the counter, absorb byte
// runs one swap per nibble, drip runs one update (UPD0 to UPD4) and then
// the output chain (OUT0 to OUT3). A shuffle, run when the absorb counter
// is full or before a drip that follows absorbed input, adds 3 x 512
// updates plus two crush passes of 128 pairs, where a pair writes back
// only when it is out of order. A drip result waits in the output register
// while the next command is taken; a second drip stalls at its last read
// until the pending byte is taken. No clearing pass follows reset.
// ----------------------------------------------------------------------------
`include "spritz_sponge_engine_defines.svh"

module spritz_sponge_engine (
  input  logic      clk_i,
  input  logic      rst_ni,
  sse_cmd_if.sink   cmd_i,
  sse_key_if.source key_o
);
  import sse_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SW0,
    ST_SW1,
    ST_SW2,
    ST_SW3,
    ST_UPD0,
    ST_UPD1,
    ST_UPD2,
    ST_UPD3,
    ST_UPD4,
    ST_OUT0,
    ST_OUT1,
    ST_OUT2,
    ST_OUT3
  } state_e;

  localparam logic [IdxW-1:0]   HalfIdx   = IdxW'(HalfSize);
  localparam logic [IdxW-1:0]   IdxMax    = IdxW'(PermSize - 1);
  localparam logic [CrushW-1:0] CrushLast = CrushW'(HalfSize - 1);
  localparam logic [RoundW-1:0] RoundLast = RoundW'(WhipRounds - 1);
  localparam logic [PhaseW-1:0] PhaseLast = PhaseW'(ShufPhases - 1);

  state_e            state_q, state_d;
  cmd_e              cmd_q, cmd_d;
  logic [7:0]        data_q, data_d;
  logic              nib_q, nib_d;
  logic              shuf_q, shuf_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [RoundW-1:0] round_q, round_d;
  logic [CrushW-1:0] v_q, v_d;
  logic [IdxW-1:0]   i_q, i_d;
  logic [IdxW-1:0]   j_q, j_d;
  logic [IdxW-1:0]   k_q, k_d;
  logic [IdxW-1:0]   w_q, w_d;
  logic [IdxW-1:0]   cnt_q, cnt_d;
  logic [IdxW-1:0]   last_q, last_d;
  logic [IdxW-1:0]   a_q, a_d;
  logic              key_vld_q, key_vld_d;

  mem_req_t          mem_req;
  logic [IdxW-1:0]   rd;
  logic [NibW-1:0]   nib;
  logic [IdxW-1:0]   sw_addr_a;
  logic [IdxW-1:0]   sw_addr_b;
  logic [IdxW-1:0]   w_inc;
  logic [IdxW-1:0]   w_next;
  logic              go_shuf;
  logic              sw_done;
  logic              upd_done;

  sse_perm_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (rd)
  );

  assign nib       = nib_q ? data_q[7:4] : data_q[3:0];
  // crush pairs v with its mirror; absorb pairs the counter with 128 + nibble
  assign sw_addr_a = shuf_q ? {1'b0, v_q} : cnt_q;
  assign sw_addr_b = shuf_q ? (IdxMax - {1'b0, v_q}) : (HalfIdx | IdxW'(nib));
  assign w_inc     = w_q + 8'd1;
  assign w_next    = w_inc[0] ? w_inc : (w_inc + 8'd1);

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    data_d    = data_q;
    nib_d     = nib_q;
    shuf_d    = shuf_q;
    phase_d   = phase_q;
    round_d   = round_q;
    v_d       = v_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    w_d       = w_q;
    cnt_d     = cnt_q;
    last_d    = last_q;
    a_d       = a_q;
    key_vld_d = key_vld_q;
    mem_req   = '0;
    go_shuf   = 1'b0;
    sw_done   = 1'b0;
    upd_done  = 1'b0;

    if (key_vld_q && key_o.ready) begin
      key_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (cmd_i.valid) begin
          cmd_d   = cmd_e'(cmd_i.command);
          data_d  = cmd_i.data_byte;
          nib_d   = 1'b0;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        case (cmd_q)
          CMD_ABSORB: begin
            if (cnt_q == HalfIdx) begin
              go_shuf = 1'b1;
            end else begin
              state_d = ST_SW0;
            end
          end
          CMD_STOP: begin
            if (cnt_q == HalfIdx) begin
              go_shuf = 1'b1;
            end else begin
              cnt_d   = cnt_q + 8'd1;
              state_d = ST_IDLE;
            end
          end
          CMD_DRIP: begin
            if (cnt_q != '0) begin
              go_shuf = 1'b1;
            end else begin
              state_d = ST_UPD0;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_SW0: begin
        mem_req.raddr = sw_addr_a;
        state_d       = ST_SW1;
      end
      ST_SW1: begin
        a_d           = rd;
        mem_req.raddr = sw_addr_b;
        state_d       = ST_SW2;
      end
      ST_SW2: begin
        if (!shuf_q || (a_q > rd)) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = sw_addr_a;
          mem_req.wdata = rd;
          state_d       = ST_SW3;
        end else begin
          sw_done = 1'b1;
        end
      end
      ST_SW3: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = sw_addr_b;
        mem_req.wdata = a_q;
        sw_done       = 1'b1;
      end
      ST_UPD0: begin
        i_d           = 8'(i_q + w_q);
        mem_req.raddr = 8'(i_q + w_q);
        state_d       = ST_UPD1;
      end
      ST_UPD1: begin
        a_d           = rd;
        mem_req.raddr = 8'(j_q + rd);
        state_d       = ST_UPD2;
      end
      ST_UPD2: begin
        j_d           = 8'(k_q + rd);
        mem_req.raddr = 8'(k_q + rd);
        state_d       = ST_UPD3;
      end
      ST_UPD3: begin
        k_d           = 8'(i_q + k_q + rd);
        mem_req.we    = 1'b1;
        mem_req.waddr = i_q;
        mem_req.wdata = rd;
        state_d       = ST_UPD4;
      end
      ST_UPD4: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = j_q;
        mem_req.wdata = a_q;
        upd_done      = 1'b1;
      end
      ST_OUT0: begin
        mem_req.raddr = 8'(last_q + k_q);
        state_d       = ST_OUT1;
      end
      ST_OUT1: begin
        mem_req.raddr = 8'(i_q + rd);
        state_d       = ST_OUT2;
      end
      ST_OUT2: begin
        a_d           = rd;
        mem_req.raddr = 8'(j_q + rd);
        state_d       = ST_OUT3;
      end
      ST_OUT3: begin
        // re-read the same entry while the previous beat is pending
        mem_req.raddr = 8'(j_q + a_q);
        if (!key_vld_q || key_o.ready) begin
          last_d    = rd;
          key_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (go_shuf) begin
      shuf_d  = 1'b1;
      phase_d = '0;
      round_d = '0;
      state_d = ST_UPD0;
    end

    if (sw_done) begin
      if (shuf_q) begin
        if (v_q == CrushLast) begin
          phase_d = phase_q + 3'd1;
          round_d = '0;
          state_d = ST_UPD0;
        end else begin
          v_d     = v_q + 7'd1;
          state_d = ST_SW0;
        end
      end else begin
        cnt_d = cnt_q + 8'd1;
        if (nib_q) begin
          state_d = ST_IDLE;
        end else begin
          nib_d   = 1'b1;
          state_d = ST_DECIDE;
        end
      end
    end

    if (upd_done) begin
      if (shuf_q) begin
        if (round_q == RoundLast) begin
          w_d     = w_next;
          round_d = '0;
          if (phase_q == PhaseLast) begin
            shuf_d  = 1'b0;
            cnt_d   = '0;
            state_d = ST_DECIDE;
          end else begin
            phase_d = phase_q + 3'd1;
            v_d     = '0;
            state_d = ST_SW0;
          end
        end else begin
          round_d = round_q + 9'd1;
          state_d = ST_UPD0;
        end
      end else begin
        state_d = ST_OUT0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cmd_q     <= CMD_ABSORB;
      data_q    <= '0;
      nib_q     <= 1'b0;
      shuf_q    <= 1'b0;
      phase_q   <= '0;
      round_q   <= '0;
      v_q       <= '0;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
      w_q       <= 8'd1;
      cnt_q     <= '0;
      last_q    <= '0;
      a_q       <= '0;
      key_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmd_q     <= cmd_d;
      data_q    <= data_d;
      nib_q     <= nib_d;
      shuf_q    <= shuf_d;
      phase_q   <= phase_d;
      round_q   <= round_d;
      v_q       <= v_d;
      i_q       <= i_d;
      j_q       <= j_d;
      k_q       <= k_d;
      w_q       <= w_d;
      cnt_q     <= cnt_d;
      last_q    <= last_d;
      a_q       <= a_d;
      key_vld_q <= key_vld_d;
    end
  end

  assign cmd_i.ready    = (state_q == ST_IDLE);
  assign key_o.valid    = key_vld_q;
  assign key_o.key_byte = last_q;

  `SSE_ASSERT(a_w_odd, w_q[0], "step w became even")
  `SSE_ASSERT(a_cnt_range, cnt_q <= HalfIdx, "absorb counter past half size")
  `SSE_ASSERT(a_swap_pair, (state_q != ST_SW1) || (sw_addr_a != sw_addr_b), "swap pair collides")
  `SSE_ASSERT_NEXT(a_out_hold, (state_q == ST_OUT3) && key_vld_q && !key_o.ready, state_q == ST_OUT3, "drip overran pending beat")

endmodule

FILE: bench/spritz_sponge_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Spritz sponge engine - testbench
// Walks a short table of directed commands, then random absorb/drip
// sequences with random gaps on both channels. Every keystream beat is
// compared against an in-bench cipher model or a hand-worked table byte.
// ----------------------------------------------------------------------------
module spritz_sponge_engine_tb;
  import sse_pkg::*;

  localparam logic [1:0] CmdUnused   = 2'd3;
  localparam int         RandItems   = 1950;
  localparam int         MaxIdle     = 12;
  localparam int         DrainCycles = 40;
  localparam int         MaxReports  = 100;
  localparam int         DirRows     = 21;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
    logic       known;
    logic [7:0] key;
  } dir_row_t;

  // Rows with known set carry a key byte worked out by hand from reset.
  dir_row_t dir_tbl [DirRows] = '{
    '{CMD_DRIP,   8'h00, 1'b1, 8'd4},
    '{CMD_DRIP,   8'h00, 1'b1, 8'd20},
    '{CMD_DRIP,   8'h00, 1'b1, 8'd69},
    '{CmdUnused,  8'hff, 1'b0, 8'h00},
    '{CMD_DRIP,   8'h00, 1'b0, 8'h00},
    '{CMD_ABSORB, 8'h00, 1'b0, 8'h00},
    '{CMD_ABSORB, 8'hff, 1'b0, 8'h00},
    '{CMD_ABSORB, 8'h0f, 1'b0, 8'h00},
    '{CMD_ABSORB, 8'hf0, 1'b0, 8'h00},
    '{CMD_ABSORB, 8'ha5, 1'b0, 8'h00},
    '{CMD_STOP,   8'hc3, 1'b0, 8'h00},
    '{CmdUnused,  8'h00, 1'b0, 8'h00},
    '{CMD_DRIP,   8'h00, 1'b0, 8'h00},
    '{CMD_DRIP,   8'hff, 1'b0, 8'h00},
    '{CMD_ABSORB, 8'h5a, 1'b0, 8'h00},
    '{CMD_STOP,   8'h00, 1'b0, 8'h00},
    '{CMD_STOP,   8'hff, 1'b0, 8'h00},
    '{CMD_DRIP,   8'h00, 1'b0, 8'h00},
    '{CMD_DRIP,   8'h00, 1'b0, 8'h00},
    '{CmdUnused,  8'h3c, 1'b0, 8'h00},
    '{CMD_DRIP,   8'h00, 1'b0, 8'h00}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  sse_cmd_if cmd_if ();
  sse_key_if key_if ();

  spritz_sponge_engine u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .key_o  (key_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Cipher state
  logic [7:0] sbox [PermSize];
  logic [7:0] ks_i, ks_j, ks_k, ks_z, ks_cnt, ks_w;

  logic [7:0] keystream_q [$];
  int         n_err;
  int         n_sent;

  task automatic report_mismatch(input string msg);
    if (n_err < MaxReports) $display("[%0t] mismatch: %s", $time, msg);
    n_err++;
  endtask

  function automatic void sbox_swap(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] x;
    x       = sbox[a];
    sbox[a] = sbox[b];
    sbox[b] = x;
  endfunction

  function automatic void cipher_update();
    logic [7:0] t;
    ks_i = ks_i + ks_w;
    t    = ks_j + sbox[ks_i];
    ks_j = ks_k + sbox[t];
    ks_k = ks_i + ks_k + sbox[ks_j];
    sbox_swap(ks_i, ks_j);
  endfunction

  function automatic void cipher_whip();
    for (int r = 0; r < WhipRounds; r++) cipher_update();
    ks_w = ks_w + 8'd1;
    if (!ks_w[0]) ks_w = ks_w + 8'd1;
  endfunction

  function automatic void cipher_crush();
    logic [7:0] lo, hi;
    for (int v = 0; v < HalfSize; v++) begin
      lo = 8'(v);
      hi = 8'(PermSize - 1 - v);
      if (sbox[lo] > sbox[hi]) sbox_swap(lo, hi);
    end
  endfunction

  function automatic void cipher_shuffle();
    cipher_whip();
    cipher_crush();
    cipher_whip();
    cipher_crush();
    cipher_whip();
    ks_cnt = 8'd0;
  endfunction

  function automatic void cipher_absorb_nibble(input logic [3:0] nib);
    if (ks_cnt == HalfSize) cipher_shuffle();
    sbox_swap(ks_cnt, {4'h8, nib});
    ks_cnt = ks_cnt + 8'd1;
  endfunction

  // Advances the cipher by one command; returns 1 when a key byte comes out.
  function automatic bit cipher_apply(input logic [1:0] cmd, input logic [7:0] data,
                                      output logic [7:0] key);
    logic [7:0] t;
    key = 8'h00;
    case (cmd)
      CMD_ABSORB: begin
        cipher_absorb_nibble(data[3:0]);
        cipher_absorb_nibble(data[7:4]);
      end
      CMD_STOP: begin
        if (ks_cnt == HalfSize) cipher_shuffle();
        ks_cnt = ks_cnt + 8'd1;
      end
      CMD_DRIP: begin
        if (ks_cnt != 8'd0) cipher_shuffle();
        cipher_update();
        t    = ks_z + ks_k;
        t    = ks_i + sbox[t];
        t    = ks_j + sbox[t];
        ks_z = sbox[t];
        key  = ks_z;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic issue_cmd(input logic [1:0] cmd, input logic [7:0] data, input bit known,
                           input logic [7:0] key, input bit burst);
    int         gap;
    logic [7:0] pred;
    gap = burst ? 0 : $urandom_range(0, MaxIdle);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.command   <= cmd;
    cmd_if.data_byte <= data;
    do @(posedge clk_i); while (cmd_if.ready !== 1'b1);
    if (cipher_apply(cmd, data, pred)) keystream_q.push_back(known ? key : pred);
    if (cmd != CmdUnused) n_sent++;
  endtask

  initial begin : key_sink
    int         stall;
    bit         burst;
    logic [7:0] want;
    key_if.ready <= 1'b0;
    burst = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 15) == 0) burst = !burst;
      stall = burst ? 0 : $urandom_range(0, MaxIdle);
      if (stall > 0) begin
        key_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      key_if.ready <= 1'b1;
      do @(posedge clk_i); while (key_if.valid !== 1'b1);
      if (keystream_q.size() == 0) begin
        report_mismatch($sformatf("unexpected key byte %02h", key_if.key_byte));
      end else begin
        want = keystream_q.pop_front();
        if (key_if.key_byte !== want)
          report_mismatch($sformatf("key byte %02h, want %02h", key_if.key_byte, want));
      end
    end
  end

  initial begin : cmd_source
    int         pick;
    int         n_abs;
    int         n_drip;
    bit         burst;
    logic [1:0] cmd;
    n_err            = 0;
    n_sent           = 0;
    rst_ni           <= 1'b0;
    cmd_if.valid     <= 1'b0;
    cmd_if.command   <= CMD_ABSORB;
    cmd_if.data_byte <= 8'h00;
    for (int n = 0; n < PermSize; n++) sbox[n] = 8'(n);
    ks_i   = 8'd0;
    ks_j   = 8'd0;
    ks_k   = 8'd0;
    ks_z   = 8'd0;
    ks_cnt = 8'd0;
    ks_w   = 8'd1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tbl[r])
      issue_cmd(dir_tbl[r].cmd, dir_tbl[r].data, dir_tbl[r].known, dir_tbl[r].key, 1'b0);

    n_sent = 0;
    while (n_sent < RandItems) begin
      burst = ($urandom_range(0, 3) == 0);
      pick  = $urandom_range(0, 19);
      if (pick == 0) begin
        // noise: any code, any order
        for (int n = 0; n < 6; n++)
          issue_cmd(2'($urandom_range(0, 3)), 8'($urandom), 1'b0, 8'h00, burst);
      end else begin
        // key absorb (long ones can fill the counter and force a shuffle), then keystream
        n_abs = (pick == 1) ? $urandom_range(66, 80) : $urandom_range(0, 10);
        for (int n = 0; n < n_abs; n++) begin
          cmd = ($urandom_range(0, 4) == 0) ? CMD_STOP : CMD_ABSORB;
          issue_cmd(cmd, 8'($urandom), 1'b0, 8'h00, burst);
        end
        n_drip = $urandom_range(8, 40);
        for (int n = 0; n < n_drip; n++)
          issue_cmd(CMD_DRIP, 8'($urandom), 1'b0, 8'h00, burst);
      end
    end
    cmd_if.valid <= 1'b0;

    while (keystream_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (n_err == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #100ms;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/sse_pkg.sv
hw/rtl/sse_if.sv
hw/rtl/sse_perm_mem.sv
hw/rtl/spritz_sponge_engine.sv
bench/spritz_sponge_engine_tb.sv
